>>> rtl/core/rtap_pkg.sv
package rtap_pkg;

  localparam logic [1:0] CFG_RADIUS_PRI = 2'd0;
  localparam logic [1:0] CFG_RADIUS_SEC = 2'd1;
  localparam logic [1:0] CFG_PLATE_CNT  = 2'd2;
  localparam logic [1:0] CFG_HEIGHT_OFS = 2'd3;

  localparam logic       CMD_LOAD    = 1'b0;

  localparam logic [32:0] HALF_PI_Q30 = 33'd1686629713;
  localparam logic [30:0] ONE_Q30     = 31'd1073741824;

  // Horner divisors: cosine series first, then sine series
  localparam int unsigned HORNER_STEPS = 9;
  localparam logic [3:0]  HK_COS_LAST  = 4'd4;
  localparam logic [3:0]  HK_LAST      = 4'd8;

  localparam logic [6:0] HORNER_DIV [HORNER_STEPS] = '{
    7'd90, 7'd56, 7'd30, 7'd12, 7'd2, 7'd72, 7'd42, 7'd20, 7'd6
  };

  // floor(2^32 / d), quotient estimate is then low by at most one
  localparam logic [31:0] HORNER_REC [HORNER_STEPS] = '{
    32'((64'd1 << 32) / 90), 32'((64'd1 << 32) / 56), 32'((64'd1 << 32) / 30),
    32'((64'd1 << 32) / 12), 32'((64'd1 << 32) / 2),  32'((64'd1 << 32) / 72),
    32'((64'd1 << 32) / 42), 32'((64'd1 << 32) / 20), 32'((64'd1 << 32) / 6)
  };

endpackage

>>> rtl/core/rotating_target_armor_predictor_top.sv
// Predicts the armor plate of a spinning target that faces the origin. A load
// transfer (command 0) sets centre position, velocity, yaw and yaw rate; an
// advance transfer (command 1) moves position and yaw by time_step. Every input
// transfer yields one result transfer. One item is worked at a time through a
// single shared 33x33 multiplier and a bit-serial square root. The per-plate
// cost is the polynomial sine and cosine (nine Horner steps, each of three
// states with two multiplier passes), and the four distances are each worked
// out in the root unit. A new input is taken while the previous result still
// waits at the output register.
module rotating_target_armor_predictor_top #(
  parameter int MAX_PLATES = 4,
  parameter int ANGLE_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_index_i,
  input  logic [16:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               command_i,
  input  logic signed [31:0] pos_x_i,
  input  logic signed [31:0] pos_y_i,
  input  logic signed [31:0] pos_z_i,
  input  logic signed [31:0] vel_x_i,
  input  logic signed [31:0] vel_y_i,
  input  logic signed [31:0] vel_z_i,
  input  logic [15:0]        yaw_angle_i,
  input  logic signed [20:0] yaw_rate_i,
  input  logic [15:0]        time_step_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               target_valid_o,
  output logic [1:0]         plate_index_o,
  output logic signed [31:0] plate_x_o,
  output logic signed [31:0] plate_y_o,
  output logic signed [31:0] plate_z_o,
  output logic [31:0]        centre_dist_2d_o,
  output logic [31:0]        centre_dist_3d_o,
  output logic [31:0]        plate_dist_2d_o,
  output logic [31:0]        plate_dist_3d_o
);
  import rtap_pkg::*;

  localparam int AB  = ANGLE_BITS;
  localparam int NB  = $clog2(MAX_PLATES + 1) + 1;
  localparam int IW  = $clog2(MAX_PLATES + 1);
  localparam int CW  = ($clog2(AB + 1) > 5) ? $clog2(AB + 1) : 5;

  typedef enum logic [4:0] {
    S_IDLE, S_ADV_MUL, S_ADV_UPD, S_DIV, S_TRIG_X, S_TRIG_X2, S_TRIG_X2R,
    S_H_MUL, S_H_REC, S_H_COR, S_SIN_MUL, S_TRIG_FIN, S_SC_MUL1, S_SC_MUL2,
    S_SC_CMP, S_PLT_X, S_PLT_Y, S_PLT_Z, S_SQ_MUL, S_SQ_ACC, S_SR_INIT,
    S_SR_STEP, S_DONE
  } state_e;

  function automatic logic signed [65:0] rnd(input logic signed [65:0] v,
                                             input int unsigned sh);
    logic [65:0] mag;
    logic [65:0] r;
    mag = v[65] ? 66'(-v) : 66'(v);
    r = (mag + (66'd1 << (sh - 1))) >> sh;
    return v[65] ? -$signed(r) : $signed(r);
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -66'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  state_e state_q;

  logic [15:0]        rad_pri_q, rad_sec_q;
  logic [2:0]         pcnt_q;
  logic signed [16:0] hofs_q;

  logic signed [31:0] pos_q [3];
  logic signed [31:0] vel_q [3];
  logic [AB-1:0]      yaw_q;
  logic signed [20:0] rate_q;
  logic               loaded_q;
  logic [15:0]        dt_q;

  logic signed [65:0] prod_q;
  logic [2:0]         k_q;
  logic [CW-1:0]      cnt_q;
  logic [NB-1:0]      n_q, rem_q, orem_q;
  logic [AB:0]        quo_q, off_q;
  logic [IW-1:0]      i_q, best_q;
  logic [1:0]         quad_q;
  logic               swap_q;
  logic [29:0]        x_q, x2_q, v_q;
  logic [30:0]        u_q;
  logic [3:0]         hk_q;
  logic signed [31:0] cv_q, c_q, s_q, best_c_q, best_s_q;
  logic signed [65:0] acc_q, best_score_q;
  logic signed [31:0] px_q, py_q, pz_q;
  logic [63:0]        c2_q, c3_q, p2_q, p3_q;
  logic [63:0]        sr_rem_q, sr_res_q, sr_bit_q;
  logic [31:0]        dist_q [4];

  logic               out_valid_q;
  logic               tv_q;
  logic [1:0]         pidx_q;
  logic signed [31:0] ox_q, oy_q, oz_q;
  logic [31:0]        ocd2_q, ocd3_q, opd2_q, opd3_q;

  // effective plate count
  logic [NB-1:0] n_eff;
  always_comb begin
    if (pcnt_q == 3'd0) n_eff = NB'(1);
    else if (32'(pcnt_q) > 32'(MAX_PLATES)) n_eff = NB'(MAX_PLATES);
    else n_eff = NB'(pcnt_q);
  end

  // plate angle and octant fold
  logic [AB-1:0] ang;
  logic [31:0]   a32;
  logic [30:0]   t_full;
  assign ang    = yaw_q + off_q[AB-1:0];
  assign a32    = {ang, {(32 - AB){1'b0}}};
  assign t_full = a32[29] ? (ONE_Q30 - {1'b0, a32[29:0]}) : {1'b0, a32[29:0]};

  // shared multiplier operands
  logic signed [32:0] mul_a, mul_b;
  logic [15:0]        r_sel;
  logic signed [16:0] dz_sel;
  logic               sel_sec;
  logic signed [31:0] sq_op;

  assign sel_sec = (n_q == NB'(4)) && best_q[0];
  assign r_sel   = sel_sec ? rad_sec_q : rad_pri_q;
  assign dz_sel  = sel_sec ? hofs_q : 17'sd0;

  always_comb begin
    case (k_q)
      3'd0:    sq_op = pos_q[0];
      3'd1:    sq_op = pos_q[1];
      3'd2:    sq_op = pos_q[2];
      3'd3:    sq_op = px_q;
      3'd4:    sq_op = py_q;
      default: sq_op = pz_q;
    endcase
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_ADV_MUL: begin
        mul_a = {17'd0, dt_q};
        if (k_q == 3'd3) mul_b = 33'(rate_q);
        else mul_b = 33'(vel_q[k_q[1:0]]);
      end
      S_TRIG_X: begin
        mul_a = {3'd0, t_full[29:0]};
        mul_b = HALF_PI_Q30;
      end
      S_TRIG_X2: begin
        mul_a = {3'd0, prod_q[59:30]};
        mul_b = {3'd0, prod_q[59:30]};
      end
      S_H_MUL: begin
        mul_a = {3'd0, x2_q};
        mul_b = {2'd0, u_q};
      end
      S_H_REC: begin
        mul_a = {3'd0, prod_q[59:30]};
        mul_b = {1'b0, HORNER_REC[hk_q]};
      end
      S_SIN_MUL: begin
        mul_a = {3'd0, x_q};
        mul_b = {2'd0, u_q};
      end
      S_SC_MUL1: begin
        mul_a = 33'(pos_q[0]);
        mul_b = 33'(c_q);
      end
      S_SC_MUL2: begin
        mul_a = 33'(pos_q[1]);
        mul_b = 33'(s_q);
      end
      S_PLT_X: begin
        mul_a = {17'd0, r_sel};
        mul_b = 33'(best_c_q);
      end
      S_PLT_Y: begin
        mul_a = {17'd0, r_sel};
        mul_b = 33'(best_s_q);
      end
      S_SQ_MUL: begin
        mul_a = 33'(sq_op);
        mul_b = 33'(sq_op);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Horner correction step
  logic [29:0] hq0;
  logic [37:0] hqd, hrem;
  logic [29:0] hq;
  logic [30:0] u_new;
  always_comb begin
    hq0   = prod_q[61:32];
    hqd   = {8'd0, hq0} * {31'd0, HORNER_DIV[hk_q]};
    hrem  = {8'd0, v_q} - hqd;
    hq    = (hrem >= {31'd0, HORNER_DIV[hk_q]}) ? hq0 + 30'd1 : hq0;
    u_new = ONE_Q30 - {1'b0, hq};
  end

  // quadrant unfold
  logic signed [31:0] sv, c0, s0, c_fin, s_fin;
  always_comb begin
    sv = {2'b00, prod_q[59:30]};
    c0 = swap_q ? sv : cv_q;
    s0 = swap_q ? cv_q : sv;
    case (quad_q)
      2'd0:    begin c_fin = c0;  s_fin = s0;  end
      2'd1:    begin c_fin = -s0; s_fin = c0;  end
      2'd2:    begin c_fin = -c0; s_fin = -s0; end
      default: begin c_fin = s0;  s_fin = -c0; end
    endcase
  end

  logic signed [65:0] score;
  logic [NB-1:0]      orem_sum;
  logic               ocarry;
  assign score    = acc_q + prod_q;
  assign orem_sum = orem_q + rem_q;
  assign ocarry   = orem_sum >= n_q;

  logic [NB-1:0] div_sh;
  logic          div_ge;
  assign div_sh = {rem_q[NB-2:0], cnt_q == CW'(AB)};
  assign div_ge = div_sh >= n_q;

  logic [63:0] sr_try;
  logic [63:0] sr_res_n;
  logic        sr_ge;
  assign sr_try   = sr_res_q + sr_bit_q;
  assign sr_ge    = sr_rem_q >= sr_try;
  assign sr_res_n = sr_ge ? ((sr_res_q >> 1) + sr_bit_q) : (sr_res_q >> 1);

  logic signed [65:0] rnd16, rnd30;
  assign rnd16 = rnd(prod_q, 16);
  assign rnd30 = rnd(prod_q, 30);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      rad_pri_q    <= 16'd16384;
      rad_sec_q    <= 16'd16384;
      pcnt_q       <= 3'd4;
      hofs_q       <= '0;
      pos_q        <= '{default: '0};
      vel_q        <= '{default: '0};
      yaw_q        <= '0;
      rate_q       <= '0;
      loaded_q     <= 1'b0;
      dt_q         <= '0;
      prod_q       <= '0;
      k_q          <= '0;
      cnt_q        <= '0;
      n_q          <= '0;
      rem_q        <= '0;
      orem_q       <= '0;
      quo_q        <= '0;
      off_q        <= '0;
      i_q          <= '0;
      best_q       <= '0;
      quad_q       <= '0;
      swap_q       <= 1'b0;
      x_q          <= '0;
      x2_q         <= '0;
      v_q          <= '0;
      u_q          <= '0;
      hk_q         <= '0;
      cv_q         <= '0;
      c_q          <= '0;
      s_q          <= '0;
      best_c_q     <= '0;
      best_s_q     <= '0;
      acc_q        <= '0;
      best_score_q <= '0;
      px_q         <= '0;
      py_q         <= '0;
      pz_q         <= '0;
      c2_q         <= '0;
      c3_q         <= '0;
      p2_q         <= '0;
      p3_q         <= '0;
      sr_rem_q     <= '0;
      sr_res_q     <= '0;
      sr_bit_q     <= '0;
      dist_q       <= '{default: '0};
      out_valid_q  <= 1'b0;
      tv_q         <= 1'b0;
      pidx_q       <= '0;
      ox_q         <= '0;
      oy_q         <= '0;
      oz_q         <= '0;
      ocd2_q       <= '0;
      ocd3_q       <= '0;
      opd2_q       <= '0;
      opd3_q       <= '0;
    end else begin
      prod_q <= mul_a * mul_b;

      if (out_valid_q && !out_stall_i && state_q != S_DONE) out_valid_q <= 1'b0;

      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_RADIUS_PRI: rad_pri_q <= cfg_data_i[15:0];
          CFG_RADIUS_SEC: rad_sec_q <= cfg_data_i[15:0];
          CFG_PLATE_CNT:  pcnt_q    <= cfg_data_i[2:0];
          CFG_HEIGHT_OFS: hofs_q    <= cfg_data_i;
          default: ;
        endcase
      end

      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            n_q   <= n_eff;
            k_q   <= '0;
            cnt_q <= CW'(AB);
            rem_q <= '0;
            quo_q <= '0;
            if (command_i == CMD_LOAD) begin
              pos_q    <= '{pos_x_i, pos_y_i, pos_z_i};
              vel_q    <= '{vel_x_i, vel_y_i, vel_z_i};
              yaw_q    <= AB'(yaw_angle_i);
              rate_q   <= yaw_rate_i;
              loaded_q <= 1'b1;
              state_q  <= S_DIV;
            end else begin
              dt_q    <= time_step_i;
              state_q <= S_ADV_MUL;
            end
          end
        end
        S_ADV_MUL: state_q <= S_ADV_UPD;
        S_ADV_UPD: begin
          if (k_q == 3'd3) begin
            yaw_q   <= yaw_q + rnd16[AB-1:0];
            state_q <= S_DIV;
          end else begin
            pos_q[k_q[1:0]] <= sat32(66'(pos_q[k_q[1:0]]) + rnd16);
            k_q     <= k_q + 3'd1;
            state_q <= S_ADV_MUL;
          end
        end
        S_DIV: begin
          rem_q <= div_ge ? div_sh - n_q : div_sh;
          quo_q <= {quo_q[AB-1:0], div_ge};
          if (cnt_q == '0) begin
            i_q     <= '0;
            off_q   <= '0;
            orem_q  <= '0;
            state_q <= S_TRIG_X;
          end else begin
            cnt_q <= cnt_q - CW'(1);
          end
        end
        S_TRIG_X: begin
          quad_q  <= a32[31:30];
          swap_q  <= a32[29];
          state_q <= S_TRIG_X2;
        end
        S_TRIG_X2: begin
          x_q     <= prod_q[59:30];
          state_q <= S_TRIG_X2R;
        end
        S_TRIG_X2R: begin
          x2_q    <= prod_q[59:30];
          u_q     <= ONE_Q30;
          hk_q    <= '0;
          state_q <= S_H_MUL;
        end
        S_H_MUL: state_q <= S_H_REC;
        S_H_REC: begin
          v_q     <= prod_q[59:30];
          state_q <= S_H_COR;
        end
        S_H_COR: begin
          if (hk_q == HK_LAST) begin
            u_q     <= u_new;
            state_q <= S_SIN_MUL;
          end else if (hk_q == HK_COS_LAST) begin
            cv_q    <= {1'b0, u_new};
            u_q     <= ONE_Q30;
            hk_q    <= hk_q + 4'd1;
            state_q <= S_H_MUL;
          end else begin
            u_q     <= u_new;
            hk_q    <= hk_q + 4'd1;
            state_q <= S_H_MUL;
          end
        end
        S_SIN_MUL: state_q <= S_TRIG_FIN;
        S_TRIG_FIN: begin
          c_q     <= c_fin;
          s_q     <= s_fin;
          state_q <= S_SC_MUL1;
        end
        S_SC_MUL1: state_q <= S_SC_MUL2;
        S_SC_MUL2: begin
          acc_q   <= prod_q;
          state_q <= S_SC_CMP;
        end
        S_SC_CMP: begin
          if (i_q == '0 || score > best_score_q) begin
            best_q       <= i_q;
            best_score_q <= score;
            best_c_q     <= c_q;
            best_s_q     <= s_q;
          end
          off_q  <= off_q + quo_q + (AB + 1)'(ocarry);
          orem_q <= ocarry ? orem_sum - n_q : orem_sum;
          i_q    <= i_q + IW'(1);
          if (NB'(i_q) + NB'(1) == n_q) state_q <= S_PLT_X;
          else state_q <= S_TRIG_X;
        end
        S_PLT_X: state_q <= S_PLT_Y;
        S_PLT_Y: begin
          px_q    <= sat32(66'(pos_q[0]) - rnd30);
          state_q <= S_PLT_Z;
        end
        S_PLT_Z: begin
          py_q    <= sat32(66'(pos_q[1]) - rnd30);
          pz_q    <= sat32(66'(pos_q[2]) + 66'(dz_sel));
          k_q     <= '0;
          state_q <= S_SQ_MUL;
        end
        S_SQ_MUL: state_q <= S_SQ_ACC;
        S_SQ_ACC: begin
          case (k_q)
            3'd0:    c2_q <= prod_q[63:0];
            3'd1:    c2_q <= c2_q + prod_q[63:0];
            3'd2:    c3_q <= c2_q + prod_q[63:0];
            3'd3:    p2_q <= prod_q[63:0];
            3'd4:    p2_q <= p2_q + prod_q[63:0];
            default: p3_q <= p2_q + prod_q[63:0];
          endcase
          if (k_q == 3'd5) begin
            k_q     <= '0;
            state_q <= S_SR_INIT;
          end else begin
            k_q     <= k_q + 3'd1;
            state_q <= S_SQ_MUL;
          end
        end
        S_SR_INIT: begin
          case (k_q[1:0])
            2'd0:    sr_rem_q <= c2_q;
            2'd1:    sr_rem_q <= c3_q;
            2'd2:    sr_rem_q <= p2_q;
            default: sr_rem_q <= p3_q;
          endcase
          sr_res_q <= '0;
          sr_bit_q <= 64'd1 << 62;
          cnt_q    <= CW'(31);
          state_q  <= S_SR_STEP;
        end
        S_SR_STEP: begin
          if (sr_ge) sr_rem_q <= sr_rem_q - sr_try;
          sr_res_q <= sr_res_n;
          sr_bit_q <= sr_bit_q >> 2;
          if (cnt_q == '0) begin
            dist_q[k_q[1:0]] <= sr_res_n[31:0];
            if (k_q == 3'd3) begin
              state_q <= S_DONE;
            end else begin
              k_q     <= k_q + 3'd1;
              state_q <= S_SR_INIT;
            end
          end else begin
            cnt_q <= cnt_q - CW'(1);
          end
        end
        S_DONE: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q <= 1'b1;
            tv_q        <= loaded_q;
            pidx_q      <= best_q[1:0];
            ox_q        <= px_q;
            oy_q        <= py_q;
            oz_q        <= pz_q;
            ocd2_q      <= dist_q[0];
            ocd3_q      <= dist_q[1];
            opd2_q      <= dist_q[2];
            opd3_q      <= dist_q[3];
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_stall_o       = (state_q != S_IDLE);
  assign out_valid_o      = out_valid_q;
  assign target_valid_o   = tv_q;
  assign plate_index_o    = pidx_q;
  assign plate_x_o        = ox_q;
  assign plate_y_o        = oy_q;
  assign plate_z_o        = oz_q;
  assign centre_dist_2d_o = ocd2_q;
  assign centre_dist_3d_o = ocd3_q;
  assign plate_dist_2d_o  = opd2_q;
  assign plate_dist_3d_o  = opd3_q;

endmodule
